>>> sv/tone_sequence_player_top_macros.svh
// ----------------------------------------------------------------------------
// Tone sequence player assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TONE_SEQUENCE_PLAYER_TOP_MACROS_SVH
`define TONE_SEQUENCE_PLAYER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tone sequence player assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tone sequence player assertion failed");

`endif

>>> sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Tone sequence player package
// Item modes, register indices, reset values and the table entry type.
// ----------------------------------------------------------------------------
package tsp_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_STEPS_IN_USE = 2'd0,
    REG_TICK_MS      = 2'd1,
    REG_GAP_MS       = 2'd2
  } reg_idx_e;

  localparam logic [6:0]  StepsInUseReset = 7'd0;
  localparam logic [7:0]  TickMsReset     = 8'd10;
  localparam logic [15:0] GapMsReset      = 16'd250;

  typedef struct packed {
    logic [15:0] tone;
    logic [15:0] duration;
    logic [7:0]  volume;
  } entry_t;

endpackage

>>> sv/tsp_table.sv
// ----------------------------------------------------------------------------
// Tone sequence player step table
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module tsp_table #(
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  tsp_pkg::entry_t              wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output tsp_pkg::entry_t              rdata_o
);

  tsp_pkg::entry_t mem_q [DEPTH];
  tsp_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tone_sequence_player_top.sv
// ----------------------------------------------------------------------------
// Tone sequence player
// Plays a stored sequence of tones, durations and volumes on a buzzer.
// ----------------------------------------------------------------------------
// Load items and unused codes are taken one per cycle while the output is not
// stalled. A tick or a start item holds off the next item: the step table has a
// registered read, and the next item's table address waits for the step index
// that the tick or start writes back. Every item gives exactly one result, held in
// an output register so that a new item is taken while a result waits. The table
// is not cleared at reset; every entry that a sequence plays must be loaded first.
`include "tone_sequence_player_top_macros.svh"

module tone_sequence_player_top #(
  parameter int MAX_STEPS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  entry_index_i,
  input  logic [15:0] entry_tone_i,
  input  logic [15:0] entry_duration_i,
  input  logic [7:0]  entry_volume_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        set_sound_o,
  output logic [15:0] tone_o,
  output logic [7:0]  volume_o,
  output logic        silence_o,
  output logic        active_o
);

  localparam int         AddrW     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic [7:0] MaxSteps8 = 8'(MAX_STEPS);

  logic [6:0]  steps_in_use_q;
  logic [7:0]  tick_ms_q;
  logic [15:0] gap_ms_q;

  logic        running_q, running_d;
  logic [6:0]  step_index_q, step_index_d;
  logic [15:0] remaining_q, remaining_d;
  logic [7:0]  cur_volume_q, cur_volume_d;

  logic                s1_valid_q;
  tsp_pkg::mode_e      s1_mode_q;
  logic                s1_adv;
  logic                in_accept;
  tsp_pkg::mode_e      in_mode;

  logic        out_valid_q;
  logic        set_sound_q, set_sound_d;
  logic [15:0] tone_q, tone_d;
  logic [7:0]  volume_q, volume_d;
  logic        silence_q, silence_d;
  logic        active_q, active_d;

  logic            tbl_we;
  logic            tbl_re;
  tsp_pkg::entry_t tbl_wdata;
  tsp_pkg::entry_t tbl_rdata;
  logic [7:0]      seq_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_in_use_q <= tsp_pkg::StepsInUseReset;
      tick_ms_q      <= tsp_pkg::TickMsReset;
      gap_ms_q       <= tsp_pkg::GapMsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsp_pkg::REG_STEPS_IN_USE: steps_in_use_q <= cfg_wdata_i[6:0];
        tsp_pkg::REG_TICK_MS:      tick_ms_q      <= cfg_wdata_i[7:0];
        tsp_pkg::REG_GAP_MS:       gap_ms_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_mode = tsp_pkg::mode_e'(mode_i);
  assign s1_adv  = s1_valid_q && (!out_valid_q || !out_stall_i);

  // A tick or start rewrites the step index, so the next table read waits.
  assign in_stall_o = s1_valid_q && (!s1_adv || s1_mode_q == tsp_pkg::MODE_TICK ||
                                     s1_mode_q == tsp_pkg::MODE_START);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign tbl_we    = in_accept && (in_mode == tsp_pkg::MODE_LOAD) &&
                     ({1'b0, entry_index_i} < MaxSteps8[6:0]);
  assign tbl_re    = in_accept && (in_mode == tsp_pkg::MODE_TICK);
  assign tbl_wdata = '{tone: entry_tone_i, duration: entry_duration_i,
                       volume: entry_volume_i};

  tsp_table #(
    .DEPTH (MAX_STEPS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (AddrW'(step_index_q)),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mode_q  <= tsp_pkg::MODE_LOAD;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      s1_mode_q  <= in_mode;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  assign seq_len = ({1'b0, steps_in_use_q} > MaxSteps8) ? MaxSteps8
                                                         : {1'b0, steps_in_use_q};

  always_comb begin
    running_d    = running_q;
    step_index_d = step_index_q;
    remaining_d  = remaining_q;
    cur_volume_d = cur_volume_q;
    set_sound_d  = 1'b0;
    tone_d       = 16'd0;
    volume_d     = 8'd0;
    silence_d    = 1'b0;
    case (s1_mode_q)
      tsp_pkg::MODE_START: begin
        running_d    = 1'b1;
        step_index_d = 7'd0;
        remaining_d  = 16'd0;
        silence_d    = 1'b1;
      end
      tsp_pkg::MODE_TICK: begin
        if (!running_q) begin
          silence_d = 1'b1;
        end else if (remaining_q > {8'd0, tick_ms_q}) begin
          remaining_d = remaining_q - {8'd0, tick_ms_q};
        end else if ({1'b0, step_index_q} >= seq_len + 8'd1) begin
          running_d = 1'b0;
          silence_d = 1'b1;
        end else begin
          if ({1'b0, step_index_q} < seq_len) begin
            tone_d       = tbl_rdata.tone;
            remaining_d  = tbl_rdata.duration;
            cur_volume_d = tbl_rdata.volume;
          end else begin
            remaining_d  = gap_ms_q;
          end
          step_index_d = step_index_q + 7'd1;
          set_sound_d  = 1'b1;
          volume_d     = cur_volume_d;
        end
      end
      default: ;
    endcase
    active_d = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      step_index_q <= 7'd0;
      remaining_q  <= 16'd0;
      cur_volume_q <= 8'd0;
    end else if (s1_adv) begin
      running_q    <= running_d;
      step_index_q <= step_index_d;
      remaining_q  <= remaining_d;
      cur_volume_q <= cur_volume_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      set_sound_q <= set_sound_d;
      tone_q      <= tone_d;
      volume_q    <= volume_d;
      silence_q   <= silence_d;
      active_q    <= active_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign set_sound_o = set_sound_q;
  assign tone_o      = tone_q;
  assign volume_o    = volume_q;
  assign silence_o   = silence_q;
  assign active_o    = active_q;

  `TSP_ASSERT_IMP(a_quiet_without_sound, out_valid_q && !set_sound_q,
                  tone_q == 16'd0 && volume_q == 8'd0)
  `TSP_ASSERT_IMP(a_sound_not_silent, out_valid_q, !(set_sound_q && silence_q))
  `TSP_ASSERT_IMP(a_active_tracks_state, out_valid_q, active_q == running_q)
  `TSP_ASSERT_IMP(a_start_clears, $rose(running_q),
                  step_index_q == 7'd0 && remaining_q == 16'd0)
  `TSP_ASSERT_NXT(a_tick_interlock,
                  s1_valid_q && s1_mode_q == tsp_pkg::MODE_TICK && !s1_adv,
                  s1_valid_q && s1_mode_q == tsp_pkg::MODE_TICK)

endmodule
